@@ rtl/core/evg_pkg.sv @@
// evg_pkg: shared widths, register indexes, reset values and control structs
// for the energy voice gate; no dependencies, compiled first

package evg_pkg;

    // field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int RMS_W      = 15;
    localparam int RMS8_W     = RMS_W + 8;
    localparam int COEF_W     = 16;
    localparam int RATIO_W    = 16;
    localparam int Y_W        = 24;
    localparam int YW_W       = 36;
    localparam int E_W        = 48;
    localparam int FLOOR_W    = 24;
    localparam int HIT_W      = 8;
    localparam int MARGIN_W   = 28;
    localparam int NF_W       = 42;

    // stream words
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 32;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;

    // shared multiplier
    localparam int MUL_W      = 25;
    localparam int PROD_W     = 2 * MUL_W;

    // shared divide / square root unit
    localparam int DS_SRC_W   = 56;
    localparam int DS_REM_W   = 30;
    localparam int DS_Q_W     = 48;
    localparam int DS_CNT_W   = 6;
    localparam int ROOT_W     = DS_REM_W - 2;
    localparam int Q2_W       = ROOT_W + 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RMS_THRESHOLD    = 4'd0,
        REG_NOISY_FLOOR      = 4'd1,
        REG_ONSET_ABS        = 4'd2,
        REG_ONSET_REL        = 4'd3,
        REG_SPEECH_RATIO_MIN = 4'd4,
        REG_FLOOR_DOWN_COEF  = 4'd5,
        REG_FLOOR_UP_COEF    = 4'd6,
        REG_HIGHPASS_COEF    = 4'd7
    } cfg_idx_t;

    localparam logic [RMS_W-1:0]  RST_RMS_THRESHOLD    = 15'd328;
    localparam logic [RMS_W-1:0]  RST_NOISY_FLOOR      = 15'd328;
    localparam logic [RMS_W-1:0]  RST_ONSET_ABS        = 15'd164;
    localparam logic [COEF_W-1:0] RST_ONSET_REL        = 16'd8192;
    localparam logic [COEF_W-1:0] RST_SPEECH_RATIO_MIN = 16'd1229;
    localparam logic [COEF_W-1:0] RST_FLOOR_DOWN_COEF  = 16'd58982;
    localparam logic [COEF_W-1:0] RST_FLOOR_UP_COEF    = 16'd65470;
    localparam logic [COEF_W-1:0] RST_HIGHPASS_COEF    = 16'd62259;

    typedef enum logic {
        DS_DIV  = 1'b0,
        DS_SQRT = 1'b1
    } ds_op_t;

    typedef struct packed {
        logic                start;
        ds_op_t              op;
        logic [DS_CNT_W-1:0] nbits;
    } ds_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ds_stat_t;

endpackage

@@ rtl/core/evg_mul.sv @@
// evg_mul: shared signed 25 x 25 multiplier with a registered product
// depends on evg_pkg

module evg_mul (
    input  logic                              aclk,
    input  logic signed [evg_pkg::MUL_W-1:0]  mul_a,
    input  logic signed [evg_pkg::MUL_W-1:0]  mul_b,
    output logic signed [evg_pkg::PROD_W-1:0] mul_p
);
    import evg_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign mul_p = prod_reg;

endmodule

@@ rtl/core/evg_divsqrt.sv @@
// evg_divsqrt: shared radix-2 restoring divider and digit-by-digit square root,
// one quotient or root bit per cycle over a single subtractor; depends on evg_pkg

module evg_divsqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  evg_pkg::ds_ctrl_t               ctrl,
    input  logic [evg_pkg::DS_SRC_W-1:0]    src,
    input  logic [evg_pkg::RMS_W-1:0]       divisor,
    output evg_pkg::ds_stat_t               stat,
    output logic [evg_pkg::DS_Q_W-1:0]      result
);
    import evg_pkg::*;

    logic                busy_reg, done_reg;
    logic [DS_CNT_W-1:0] cnt_reg;
    ds_op_t              op_reg;
    logic [RMS_W-1:0]    divisor_reg;
    logic [DS_SRC_W-1:0] src_reg, src_next;
    logic [DS_REM_W-1:0] rem_reg, rem_next;
    logic [DS_Q_W-1:0]   q_reg, q_next;

    logic [DS_REM_W-1:0] trial_a, trial_b;
    logic [DS_REM_W:0]   diff;
    logic                ge;

    // operand bits are taken from the top of src, msb first
    always_comb begin
        if (op_reg == DS_SQRT) begin
            trial_a  = {rem_reg[DS_REM_W-3:0], src_reg[DS_SRC_W-1 -: 2]};
            trial_b  = {q_reg[ROOT_W-1:0], 2'b01};
            src_next = {src_reg[DS_SRC_W-3:0], 2'b00};
        end else begin
            trial_a  = {rem_reg[DS_REM_W-2:0], src_reg[DS_SRC_W-1]};
            trial_b  = DS_REM_W'(divisor_reg);
            src_next = {src_reg[DS_SRC_W-2:0], 1'b0};
        end
        diff     = {1'b0, trial_a} - {1'b0, trial_b};
        ge       = ~diff[DS_REM_W];
        rem_next = ge ? diff[DS_REM_W-1:0] : trial_a;
        q_next   = {q_reg[DS_Q_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.nbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DS_CNT_W'(1);
                if (cnt_reg == DS_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            op_reg      <= ctrl.op;
            divisor_reg <= divisor;
            src_reg     <= src;
            rem_reg     <= '0;
            q_reg       <= '0;
        end else if (busy_reg) begin
            src_reg <= src_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = q_reg;

endmodule

@@ rtl/core/energy_voice_gate_unit.sv @@
// energy_voice_gate_unit: top level of the energy voice gate with noise floor
// tracking; depends on evg_pkg, evg_mul and evg_divsqrt

// Each audio word is one Q15 sample of a hop, carrying the hop rms; the last
// word of a hop (tlast) gives one result word with the gate decision, the
// Q4.12 speech ratio and the updated Q15 noise floor. A clear word (tuser set)
// empties the hit counter and gives nothing. Everything runs through one
// registered 25x25 multiplier and one bit-per-cycle divide/square-root unit
// under a small sequencer, and the input is not ready while a word is in work.
// A sample inside a hop runs through filter product, filter add, square and
// accumulate steps. A hop-closing sample passes the shared divide/root unit
// for energy over count, the root and the division by hop rms, and then the
// decision and floor update; with zero hop rms the divide steps are skipped.
// A finished result sits in the output register, so following samples are
// taken while it waits; a second hop end waits until that word is taken.
// Configuration writes are always ready and must only be issued while idle.

module energy_voice_gate_unit #(
    parameter int HOP_MAX     = 1024,
    parameter int HITS_NEEDED = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [evg_pkg::S_TDATA_W-1:0]     s_tdata,   // sample[15:0], hop_rms[30:16]
    input  logic [evg_pkg::S_TUSER_W-1:0]     s_tuser,   // req_type[0]
    input  logic                              s_tlast,   // last_in_hop
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [evg_pkg::M_TDATA_W-1:0]     m_tdata,   // gate_open[0], speech_ratio[16:1],
                                                         // noise_floor_level[31:17]
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [evg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [evg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import evg_pkg::*;

    localparam int CNT_W = $clog2(HOP_MAX + 1);

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);
    localparam logic signed [YW_W-1:0]   Y_MAX_W  = YW_W'((2 ** (Y_W - 1)) - 1);
    localparam logic signed [YW_W-1:0]   Y_MIN_W  = -YW_W'(2 ** (Y_W - 1));
    localparam logic [NF_W-1:0]          NF_HALF  = NF_W'(32768);

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_HP_MUL   = 16'h0002,
        ST_HP_ADD   = 16'h0004,
        ST_SQ_MUL   = 16'h0008,
        ST_ACC      = 16'h0010,
        ST_E_DIV    = 16'h0020,
        ST_E_DIV_W  = 16'h0040,
        ST_R_SQRT   = 16'h0080,
        ST_R_SQRT_W = 16'h0100,
        ST_Q_DIV    = 16'h0200,
        ST_Q_DIV_W  = 16'h0400,
        ST_HITS     = 16'h0800,
        ST_MARGIN   = 16'h1000,
        ST_DECIDE   = 16'h2000,
        ST_FLOOR    = 16'h4000,
        ST_OUT      = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [RMS_W-1:0]  rms_threshold_reg, noisy_floor_reg, onset_abs_reg;
    logic [COEF_W-1:0] onset_rel_reg, speech_ratio_min_reg;
    logic [COEF_W-1:0] floor_down_coef_reg, floor_up_coef_reg, highpass_coef_reg;

    // running state
    logic signed [SAMPLE_W-1:0] hp_prev_in_reg;
    logic signed [Y_W-1:0]      hp_prev_out_reg;
    logic [E_W-1:0]             energy_sum_reg;
    logic [CNT_W-1:0]           sample_count_reg;
    logic [HIT_W-1:0]           hit_count_reg;
    logic [FLOOR_W-1:0]         floor_level_reg;
    logic [RATIO_W-1:0]         last_ratio_reg;

    // per word working registers
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [RMS_W-1:0]           rms_reg;
    logic                       last_reg;
    logic [MARGIN_W-1:0]        margin_reg;
    logic [PROD_W-1:0]          flp_reg;
    logic                       open_reg;

    // output register
    logic                       m_tvalid_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg;

    // shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    ds_ctrl_t                 ds_ctrl;
    ds_stat_t                 ds_stat;
    logic [DS_SRC_W-1:0]      ds_src;
    logic [RMS_W-1:0]         ds_divisor;
    logic [DS_Q_W-1:0]        ds_result;

    // datapath helpers
    logic                     s_acc;
    logic [RMS8_W-1:0]        rms8;
    logic                     below_floor;
    logic [COEF_W-1:0]        w_coef;
    logic [COEF_W:0]          w_inv;
    logic signed [PROD_W-1:0] rnd_sum, rnd_sh;
    logic signed [YW_W-1:0]   y_wide;
    logic signed [Y_W-1:0]    y_sat;
    logic [E_W:0]             e_sum;
    logic [MARGIN_W-1:0]      rel, abs8;
    logic [MARGIN_W:0]        lim_full, lim_half;
    logic                     hits_full, quiet_room, ratio_ok;
    logic [NF_W-1:0]          nf;

    evg_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    evg_divsqrt u_ds (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ds_ctrl),
        .src     (ds_src),
        .divisor (ds_divisor),
        .stat    (ds_stat),
        .result  (ds_result)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // floor tracking weight, picked on the old floor
    assign rms8        = {rms_reg, 8'b0};
    assign below_floor = (FLOOR_W'(rms8) < floor_level_reg);
    assign w_coef      = below_floor ? floor_down_coef_reg : floor_up_coef_reg;
    assign w_inv       = (COEF_W + 1)'(2 ** COEF_W) - {1'b0, w_coef};

    // high-pass: round c * y_prev at q15 half up, then saturate to 24 bits
    always_comb begin
        rnd_sum = mul_p + RND_HALF;
        rnd_sh  = rnd_sum >>> 16;
        y_wide  = YW_W'(x_reg) - YW_W'(hp_prev_in_reg) + $signed(rnd_sh[YW_W-1:0]);
        if (y_wide > Y_MAX_W) begin
            y_sat = Y_MAX_W[Y_W-1:0];
        end else if (y_wide < Y_MIN_W) begin
            y_sat = Y_MIN_W[Y_W-1:0];
        end else begin
            y_sat = y_wide[Y_W-1:0];
        end
    end

    // energy accumulate, saturating
    assign e_sum = {1'b0, energy_sum_reg} + {1'b0, mul_p[E_W-1:0]};

    // onset margin and decision
    assign rel        = mul_p[MARGIN_W+11:12];
    assign abs8       = MARGIN_W'({onset_abs_reg, 8'b0});
    assign lim_full   = (MARGIN_W + 1)'(floor_level_reg) + (MARGIN_W + 1)'(margin_reg);
    assign lim_half   = (MARGIN_W + 1)'(floor_level_reg) + (MARGIN_W + 1)'(margin_reg >> 1);
    assign hits_full  = (hit_count_reg >= HIT_W'(HITS_NEEDED));
    assign quiet_room = (floor_level_reg <= FLOOR_W'({noisy_floor_reg, 8'b0}));
    assign ratio_ok   = (last_ratio_reg >= speech_ratio_min_reg);

    // floor update: old-floor term sits in flp_reg, new-level term in the product
    assign nf = flp_reg[NF_W-1:0] + mul_p[NF_W-1:0] + NF_HALF;

    // multiplier operands by step
    always_comb begin
        unique case (state_reg)
            ST_HP_MUL: begin
                mul_a = $signed(MUL_W'(highpass_coef_reg));
                mul_b = MUL_W'(hp_prev_out_reg);
            end
            ST_SQ_MUL: begin
                mul_a = MUL_W'(hp_prev_out_reg);
                mul_b = MUL_W'(hp_prev_out_reg);
            end
            ST_HITS: begin
                mul_a = $signed(MUL_W'(onset_rel_reg));
                mul_b = $signed(MUL_W'(floor_level_reg));
            end
            ST_MARGIN: begin
                mul_a = $signed(MUL_W'(w_coef));
                mul_b = $signed(MUL_W'(floor_level_reg));
            end
            ST_DECIDE: begin
                mul_a = $signed(MUL_W'(w_inv));
                mul_b = $signed(MUL_W'(rms8));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divide / root requests: energy over count, root of that times 256,
    // then root times 256 over hop rms
    always_comb begin
        ds_ctrl.start = 1'b0;
        ds_ctrl.op    = DS_DIV;
        ds_ctrl.nbits = DS_CNT_W'(E_W);
        ds_src        = {energy_sum_reg, 8'b0};
        ds_divisor    = RMS_W'(sample_count_reg);
        unique case (state_reg)
            ST_E_DIV: begin
                ds_ctrl.start = (rms_reg != '0) && (sample_count_reg != '0);
            end
            ST_R_SQRT: begin
                ds_ctrl.start = 1'b1;
                ds_ctrl.op    = DS_SQRT;
                ds_ctrl.nbits = DS_CNT_W'(ROOT_W);
                ds_src        = {ds_result, 8'b0};
            end
            ST_Q_DIV: begin
                ds_ctrl.start = 1'b1;
                ds_ctrl.nbits = DS_CNT_W'(Q2_W);
                ds_src        = {ds_result[ROOT_W-1:0], (DS_SRC_W - ROOT_W)'(0)};
                ds_divisor    = rms_reg;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && !s_tuser[0]) begin
                    if (sample_count_reg < CNT_W'(HOP_MAX)) begin
                        state_next = ST_HP_MUL;
                    end else if (s_tlast) begin
                        state_next = ST_E_DIV;
                    end
                end
            end
            ST_HP_MUL:   state_next = ST_HP_ADD;
            ST_HP_ADD:   state_next = ST_SQ_MUL;
            ST_SQ_MUL:   state_next = ST_ACC;
            ST_ACC:      state_next = last_reg ? ST_E_DIV : ST_IDLE;
            ST_E_DIV:    state_next = ds_ctrl.start ? ST_E_DIV_W : ST_HITS;
            ST_E_DIV_W:  state_next = ds_stat.done ? ST_R_SQRT : ST_E_DIV_W;
            ST_R_SQRT:   state_next = ST_R_SQRT_W;
            ST_R_SQRT_W: state_next = ds_stat.done ? ST_Q_DIV : ST_R_SQRT_W;
            ST_Q_DIV:    state_next = ST_Q_DIV_W;
            ST_Q_DIV_W:  state_next = ds_stat.done ? ST_HITS : ST_Q_DIV_W;
            ST_HITS:     state_next = ST_MARGIN;
            ST_MARGIN:   state_next = ST_DECIDE;
            ST_DECIDE:   state_next = ST_FLOOR;
            ST_FLOOR:    state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // control and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            m_tvalid_reg         <= 1'b0;
            rms_threshold_reg    <= RST_RMS_THRESHOLD;
            noisy_floor_reg      <= RST_NOISY_FLOOR;
            onset_abs_reg        <= RST_ONSET_ABS;
            onset_rel_reg        <= RST_ONSET_REL;
            speech_ratio_min_reg <= RST_SPEECH_RATIO_MIN;
            floor_down_coef_reg  <= RST_FLOOR_DOWN_COEF;
            floor_up_coef_reg    <= RST_FLOOR_UP_COEF;
            highpass_coef_reg    <= RST_HIGHPASS_COEF;
            hp_prev_in_reg       <= '0;
            hp_prev_out_reg      <= '0;
            energy_sum_reg       <= '0;
            sample_count_reg     <= '0;
            hit_count_reg        <= '0;
            floor_level_reg      <= '0;
            last_ratio_reg       <= '0;
        end else begin
            state_reg <= state_next;

            // register writes; unknown indexes fall through
            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_addr))
                    REG_RMS_THRESHOLD:    rms_threshold_reg    <= cfg_data[RMS_W-1:0];
                    REG_NOISY_FLOOR:      noisy_floor_reg      <= cfg_data[RMS_W-1:0];
                    REG_ONSET_ABS:        onset_abs_reg        <= cfg_data[RMS_W-1:0];
                    REG_ONSET_REL:        onset_rel_reg        <= cfg_data;
                    REG_SPEECH_RATIO_MIN: speech_ratio_min_reg <= cfg_data;
                    REG_FLOOR_DOWN_COEF:  floor_down_coef_reg  <= cfg_data;
                    REG_FLOOR_UP_COEF:    floor_up_coef_reg    <= cfg_data;
                    REG_HIGHPASS_COEF:    highpass_coef_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end

            // a clear word only empties the hit counter
            if (s_acc && s_tuser[0]) begin
                hit_count_reg <= '0;
            end

            if (state_reg == ST_HP_ADD) begin
                hp_prev_in_reg  <= x_reg;
                hp_prev_out_reg <= y_sat;
            end

            if (state_reg == ST_ACC) begin
                energy_sum_reg   <= e_sum[E_W] ? {E_W{1'b1}} : e_sum[E_W-1:0];
                sample_count_reg <= sample_count_reg + CNT_W'(1);
            end

            // zero rms: filter history is dropped and the ratio is zero
            if ((state_reg == ST_E_DIV) && !ds_ctrl.start) begin
                hp_prev_in_reg  <= '0;
                hp_prev_out_reg <= '0;
                last_ratio_reg  <= '0;
            end

            if ((state_reg == ST_Q_DIV_W) && ds_stat.done) begin
                last_ratio_reg <= (ds_result[DS_Q_W-1:RATIO_W] != '0) ? {RATIO_W{1'b1}}
                                                                       : ds_result[RATIO_W-1:0];
            end

            // hop closed: restart the energy window and move the hit counter
            if (state_reg == ST_HITS) begin
                energy_sum_reg   <= '0;
                sample_count_reg <= '0;
                if (rms_reg > rms_threshold_reg) begin
                    if (hit_count_reg < HIT_W'(HITS_NEEDED)) begin
                        hit_count_reg <= hit_count_reg + HIT_W'(1);
                    end
                end else if (hit_count_reg != '0) begin
                    hit_count_reg <= hit_count_reg - HIT_W'(1);
                end
            end

            if (state_reg == ST_FLOOR) begin
                floor_level_reg <= nf[FLOOR_W+15:16];
            end

            // output register, refilled only once the last word is taken
            if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            x_reg    <= $signed(s_tdata[SAMPLE_W-1:0]);
            rms_reg  <= s_tdata[SAMPLE_W+RMS_W-1:SAMPLE_W];
            last_reg <= s_tlast;
        end
        if (state_reg == ST_MARGIN) begin
            margin_reg <= (rel > abs8) ? rel : abs8;
        end
        if (state_reg == ST_DECIDE) begin
            flp_reg  <= mul_p;
            open_reg <= hits_full &&
                        (quiet_room ||
                         ((MARGIN_W + 1)'(rms8) >= lim_full) ||
                         (ratio_ok && ((MARGIN_W + 1)'(rms8) >= lim_half)));
        end
        if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {floor_level_reg[RMS_W+7:8], last_ratio_reg, open_reg};
        end
    end

    // the shared divide unit is never restarted mid-run
    a_ds_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ds_ctrl.start |-> !ds_stat.busy)
        else $error("divide/root unit started while busy");

    // a divide/root completion is only ever awaited in a wait step
    a_ds_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        ds_stat.done |-> (state_reg == ST_E_DIV_W || state_reg == ST_R_SQRT_W ||
                          state_reg == ST_Q_DIV_W))
        else $error("divide/root result arrived outside a wait step");

    a_hits_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_count_reg <= HIT_W'(HITS_NEEDED))
        else $error("hit counter beyond its ceiling");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_count_reg <= CNT_W'(HOP_MAX))
        else $error("sample count beyond hop length");

    // a hop-closing sample always starts work and drops ready
    a_hop_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_tuser[0] && s_tlast) |=> !s_tready)
        else $error("hop end accepted without starting its work");

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking bench for energy_voice_gate_unit, stream words in and out,
// with its own bit-true model of filter, hop ratio, hit counter, gate and floor
// depends on evg_pkg and the rtl of energy_voice_gate_unit only
`timescale 1ns / 1ps

module tb;
    import evg_pkg::*;

    // block parameters, kept at the defaults of the unit
    localparam int HOP_LIMIT   = 1024;
    localparam int HIT_TARGET  = 3;

    // bench timing
    localparam int QUIET_CYCLES = 32;      // a non-closing word is done well within this
    localparam int DRAIN_GUARD  = 400000;
    localparam int TAIL_CYCLES  = 200;     // long enough for one hop end to finish
    localparam int PHASE_WORDS  = 210;

    // first register index that maps to nothing
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_BASE = 4'd8;

    localparam longint unsigned ENERGY_CAP = 64'h0000_FFFF_FFFF_FFFF;

    typedef longint unsigned u64_t;

    typedef enum bit {
        REQ_SAMPLE = 1'b0,
        REQ_CLEAR  = 1'b1
    } req_kind_t;

    // packed in the order of m_tdata, lowest field last
    typedef struct packed {
        logic [RMS_W-1:0]   level;
        logic [RATIO_W-1:0] ratio;
        logic               gate;
    } gate_word_t;

    typedef struct packed {
        req_kind_t          kind;
        logic [15:0]        smp;
        logic [RMS_W-1:0]   rms;
        logic               last;
        logic               typed;
        gate_word_t         want;
    } probe_row_t;

    typedef enum {
        SET_DEFAULT,
        SET_ZERO,
        SET_FULL,
        SET_NOISY_ROOM,
        SET_SCRAMBLED,
        SET_NOISY_FAST
    } setting_kind_t;

    // ---------------------------------------------------------------------
    // clock, reset and the block
    // ---------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;     // sample[15:0], hop_rms[30:16]
    logic [S_TUSER_W-1:0]  s_tuser;     // req_type[0]
    logic                  s_tlast;     // last_in_hop
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;     // gate_open[0], speech_ratio[16:1],
                                        // noise_floor_level[31:17]
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    always #2 aclk = ~aclk;

    energy_voice_gate_unit #(
        .HOP_MAX     (HOP_LIMIT),
        .HITS_NEEDED (HIT_TARGET)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------
    // model state: register copy and the block's own state
    // ---------------------------------------------------------------------
    int unsigned gate_reg [8];
    int          hpf_x_prev;     // previous filter input, q15
    longint      hpf_y_prev;     // previous filter output, q15 in 24 bits
    u64_t        energy_acc;     // sum of squared filter output, q30
    int unsigned hop_len;        // samples counted in the open hop
    int          hits;           // saturating loud-hop counter
    int unsigned floor_q23;      // noise floor, q23
    int unsigned ratio_q12;      // speech ratio of the last closed hop

    gate_word_t  results_due [$];

    int          fail_count;
    int          words_sent;
    int          clears_sent;
    int          hops_checked;
    int          cfg_writes;
    bit          idle_on;
    int          stall_left;
    logic [15:0] next_setting [8];

    // ---------------------------------------------------------------------
    // model arithmetic
    // ---------------------------------------------------------------------

    // integer square root, built one result bit at a time (input below 2^60)
    function automatic u64_t root_floor(input u64_t v);
        u64_t root;
        u64_t trial;
        root = 0;
        for (int b = 29; b >= 0; b--) begin
            trial = root | (u64_t'(1) << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // high-pass step y = x - x_prev + c*y_prev, product rounded half up at q15
    function automatic void highpass_accumulate(input logic signed [15:0] x);
        longint prod;
        longint y;
        u64_t   sq;
        prod = longint'(gate_reg[REG_HIGHPASS_COEF]) * hpf_y_prev;
        y = longint'(x) - longint'(hpf_x_prev) + ((prod + 64'sd32768) >>> 16);
        if (y > 64'sd8388607)
            y = 64'sd8388607;
        if (y < -64'sd8388608)
            y = -64'sd8388608;
        hpf_x_prev = int'(x);
        hpf_y_prev = y;
        sq = y * y;
        energy_acc = (ENERGY_CAP - energy_acc < sq) ? ENERGY_CAP : energy_acc + sq;
    endfunction

    // one accepted input word; returns 1 when it closes a hop
    function automatic bit gate_predict(input req_kind_t kind, input logic [15:0] smp,
                                        input logic [RMS_W-1:0] rms, input bit last,
                                        output gate_word_t word);
        u64_t fl;
        u64_t rms8;
        u64_t quiet_lim;
        u64_t margin;
        u64_t rel;
        u64_t w;
        u64_t nf;
        u64_t r;
        u64_t q;
        bit   opened;
        word = '0;
        if (kind == REQ_CLEAR) begin
            hits = 0;
            return 1'b0;
        end
        if (hop_len < HOP_LIMIT) begin
            highpass_accumulate(smp);
            hop_len++;
        end
        if (!last)
            return 1'b0;

        // ratio of high-passed rms over hop rms; silent hop resets the filter
        if (rms == 0 || hop_len == 0) begin
            hpf_x_prev = 0;
            hpf_y_prev = 0;
            ratio_q12  = 0;
        end else begin
            r = root_floor((energy_acc / hop_len) * 256);
            q = (r << 8) / rms;
            ratio_q12 = (q > 65535) ? 65535 : int'(q);
        end
        energy_acc = 0;
        hop_len    = 0;

        if (rms > gate_reg[REG_RMS_THRESHOLD]) begin
            if (hits < HIT_TARGET)
                hits++;
        end else if (hits > 0) begin
            hits--;
        end

        fl   = floor_q23;
        rms8 = rms;
        rms8 = rms8 << 8;
        opened = 1'b0;
        if (hits >= HIT_TARGET) begin
            quiet_lim = gate_reg[REG_NOISY_FLOOR];
            quiet_lim = quiet_lim << 8;
            if (fl <= quiet_lim) begin
                opened = 1'b1;
            end else begin
                // noisy room: onset margin is the larger of absolute and relative
                margin = gate_reg[REG_ONSET_ABS];
                margin = margin << 8;
                rel    = (fl * gate_reg[REG_ONSET_REL]) >> 12;
                if (rel > margin)
                    margin = rel;
                opened = (rms8 >= fl + margin) ||
                         (ratio_q12 >= gate_reg[REG_SPEECH_RATIO_MIN] &&
                          rms8 >= fl + (margin >> 1));
            end
        end

        // asymmetric floor tracking
        w  = (rms8 < fl) ? gate_reg[REG_FLOOR_DOWN_COEF] : gate_reg[REG_FLOOR_UP_COEF];
        nf = (w * fl + (65536 - w) * rms8 + 32768) >> 16;
        floor_q23 = int'(nf & 64'hFF_FFFF);

        word.gate  = opened;
        word.ratio = ratio_q12[RATIO_W-1:0];
        word.level = floor_q23[RMS_W+7:8];
        return 1'b1;
    endfunction

    function automatic void apply_setting(input logic [CFG_ADDR_W-1:0] a,
                                          input logic [CFG_DATA_W-1:0] d);
        case (a)
            REG_RMS_THRESHOLD, REG_NOISY_FLOOR, REG_ONSET_ABS:
                gate_reg[a[2:0]] = d[RMS_W-1:0];
            REG_ONSET_REL, REG_SPEECH_RATIO_MIN, REG_FLOOR_DOWN_COEF,
            REG_FLOOR_UP_COEF, REG_HIGHPASS_COEF:
                gate_reg[a[2:0]] = d;
            default: ;      // spare index, write dropped
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // random content
    // ---------------------------------------------------------------------

    // hop level: silence, quiet, around the loudness threshold, just above the floor, or fully random
    function automatic logic [RMS_W-1:0] pick_level();
        int unsigned t;
        int unsigned lo;
        int unsigned hi;
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return RMS_W'($urandom_range(1, 400));
            3, 4: begin
                t  = gate_reg[REG_RMS_THRESHOLD];
                lo = (t > 2) ? t - 2 : 0;
                hi = (t + 2 > 32767) ? 32767 : t + 2;
                return RMS_W'($urandom_range(lo, hi));
            end
            5, 6: begin
                t = (floor_q23 >> 8) + $urandom_range(0, 3000);
                return RMS_W'((t > 32767) ? 32767 : t);
            end
            default: return RMS_W'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        logic signed [15:0] s;
        s = 16'($urandom);
        case ($urandom_range(0, 3))
            1: return s >>> $urandom_range(4, 12);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return s;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // drivers: inputs move on the falling edge, handshakes seen on the rising
    // ---------------------------------------------------------------------

    // one input word; a typed row replaces the model's answer by a literal
    task automatic send_word(input req_kind_t kind, input logic [15:0] smp,
                             input logic [RMS_W-1:0] rms, input bit last,
                             input bit typed, input gate_word_t want);
        int         gap;
        gate_word_t word;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, rms, smp};
        s_tuser  <= kind;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (gate_predict(kind, smp, rms, last, word))
            results_due.push_back(typed ? want : word);
        words_sent++;
        if (kind == REQ_CLEAR)
            clears_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= a;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        apply_setting(a, d);
        cfg_writes++;
    endtask

    // spare index first, then every register from next_setting
    task automatic load_settings();
        cfg_write(REG_SPARE_BASE + CFG_ADDR_W'($urandom_range(0, 7)), 16'($urandom));
        for (int i = 0; i < 8; i++)
            cfg_write(cfg_idx_t'(i), next_setting[i]);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // sender holds off until every result is home and the block is idle
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // whole hops of random length and content, with clear words sprinkled in
    task automatic run_hops(input int n);
        int               start;
        int               len;
        logic [RMS_W-1:0] hop_level;
        logic [RMS_W-1:0] lvl;
        start = words_sent;
        while (words_sent - start < n) begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 48);
            hop_level = pick_level();
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 24) == 0)
                    send_word(REQ_CLEAR, 16'($urandom), RMS_W'($urandom),
                              $urandom_range(0, 1), 1'b0, '0);
                // earlier samples may carry a stray level, only the last one counts
                lvl = (i != len - 1 && $urandom_range(0, 4) == 0) ? RMS_W'($urandom)
                                                                   : hop_level;
                send_word(REQ_SAMPLE, pick_sample(), lvl, i == len - 1, 1'b0, '0);
            end
        end
    endtask

    // receiver: stalls in random bursts while idling is on
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // result check, field by field against the oldest expectation
    // ---------------------------------------------------------------------
    gate_word_t due_word;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("result word %h arrived with nothing expected", m_tdata);
                fail_count++;
            end else begin
                due_word = results_due.pop_front();
                hops_checked++;
                if (m_tdata[0] !== due_word.gate) begin
                    $error("gate_open: expected %0d, got %0d", due_word.gate, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[16:1] !== due_word.ratio) begin
                    $error("speech_ratio: expected %0d, got %0d",
                           due_word.ratio, m_tdata[16:1]);
                    fail_count++;
                end
                if (m_tdata[31:17] !== due_word.level) begin
                    $error("noise_floor_level: expected %0d, got %0d",
                           due_word.level, m_tdata[31:17]);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // directed words, at reset settings
    // ---------------------------------------------------------------------
    localparam int NUM_PROBES = 19;

    // typed rows: a silent hop straight after reset gives all zeros; a single
    // full-scale sample whose hop rms equals it gives ratio exactly 1.0 (4096)
    // and lifts the empty floor by 66/65536 of full scale, 33 at q15
    probe_row_t probe_rows [NUM_PROBES] = '{
        '{REQ_SAMPLE, 16'h0000, 15'd0,     1'b1, 1'b1, '{15'd0,  16'd0,    1'b0}},
        '{REQ_SAMPLE, 16'h7FFF, 15'd32767, 1'b1, 1'b1, '{15'd33, 16'd4096, 1'b0}},
        // clear word with every other field at its top
        '{REQ_CLEAR,  16'hFFFF, 15'd32767, 1'b1, 1'b0, '0},
        // tiny hop rms against a full-scale swing: ratio saturates
        '{REQ_SAMPLE, 16'h8000, 15'd1,     1'b1, 1'b0, '0},
        // hop whose level changes on the way, last one wins
        '{REQ_SAMPLE, 16'h1234, 15'd20000, 1'b0, 1'b0, '0},
        '{REQ_SAMPLE, 16'hEDCC, 15'd0,     1'b0, 1'b0, '0},
        '{REQ_SAMPLE, 16'h7FFF, 15'd5000,  1'b1, 1'b0, '0},
        // second loud hop since the clear, in a quiet room, still one short of opening
        '{REQ_SAMPLE, 16'h0100, 15'd3000,  1'b1, 1'b0, '0},
        // one above and exactly at the loudness threshold
        '{REQ_SAMPLE, 16'h0000, 15'd329,   1'b1, 1'b0, '0},
        '{REQ_SAMPLE, 16'h0000, 15'd328,   1'b1, 1'b0, '0},
        // clear in the middle of a hop leaves the filter alone
        '{REQ_SAMPLE, 16'h4000, 15'd1000,  1'b0, 1'b0, '0},
        '{REQ_CLEAR,  16'h0000, 15'd0,     1'b0, 1'b0, '0},
        '{REQ_SAMPLE, 16'hC000, 15'd1000,  1'b1, 1'b0, '0},
        // multi-sample silent hop clears the filter
        '{REQ_SAMPLE, 16'h0001, 15'd0,     1'b0, 1'b0, '0},
        '{REQ_SAMPLE, 16'hFFFF, 15'd0,     1'b1, 1'b0, '0},
        // loud streak with alternating bit patterns
        '{REQ_SAMPLE, 16'h5555, 15'd32767, 1'b1, 1'b0, '0},
        '{REQ_SAMPLE, 16'hAAAA, 15'd32767, 1'b1, 1'b0, '0},
        '{REQ_SAMPLE, 16'h7FFF, 15'd32767, 1'b1, 1'b0, '0},
        // level under the floor, floor falls with the down weight
        '{REQ_SAMPLE, 16'h0000, 15'd1,     1'b1, 1'b0, '0}
    };

    // ---------------------------------------------------------------------
    // sequence of the run
    // ---------------------------------------------------------------------
    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        idle_on    = 1'b1;
        stall_left = 0;
        fail_count = 0;
        words_sent = 0;
        clears_sent  = 0;
        hops_checked = 0;
        cfg_writes   = 0;

        // model at its reset state
        gate_reg[REG_RMS_THRESHOLD]    = RST_RMS_THRESHOLD;
        gate_reg[REG_NOISY_FLOOR]      = RST_NOISY_FLOOR;
        gate_reg[REG_ONSET_ABS]        = RST_ONSET_ABS;
        gate_reg[REG_ONSET_REL]        = RST_ONSET_REL;
        gate_reg[REG_SPEECH_RATIO_MIN] = RST_SPEECH_RATIO_MIN;
        gate_reg[REG_FLOOR_DOWN_COEF]  = RST_FLOOR_DOWN_COEF;
        gate_reg[REG_FLOOR_UP_COEF]    = RST_FLOOR_UP_COEF;
        gate_reg[REG_HIGHPASS_COEF]    = RST_HIGHPASS_COEF;
        hpf_x_prev = 0;
        hpf_y_prev = 0;
        energy_acc = 0;
        hop_len    = 0;
        hits       = 0;
        floor_q23  = 0;
        ratio_q12  = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int k = 0; k < NUM_PROBES; k++)
            send_word(probe_rows[k].kind, probe_rows[k].smp, probe_rows[k].rms,
                      probe_rows[k].last, probe_rows[k].typed, probe_rows[k].want);
        settle();

        // one hop running past the length cap, closed by an uncounted sample
        for (int i = 0; i < HOP_LIMIT + 3; i++)
            send_word(REQ_SAMPLE, pick_sample(), RMS_W'($urandom_range(1, 32767)),
                      i == HOP_LIMIT + 2, 1'b0, '0);
        settle();

        // random hops under a sequence of settings, block idle at each change
        for (int p = SET_DEFAULT; p <= SET_NOISY_FAST; p++) begin
            case (setting_kind_t'(p))
                SET_DEFAULT: begin
                    next_setting[REG_RMS_THRESHOLD]    = RST_RMS_THRESHOLD;
                    next_setting[REG_NOISY_FLOOR]      = RST_NOISY_FLOOR;
                    next_setting[REG_ONSET_ABS]        = RST_ONSET_ABS;
                    next_setting[REG_ONSET_REL]        = RST_ONSET_REL;
                    next_setting[REG_SPEECH_RATIO_MIN] = RST_SPEECH_RATIO_MIN;
                    next_setting[REG_FLOOR_DOWN_COEF]  = RST_FLOOR_DOWN_COEF;
                    next_setting[REG_FLOOR_UP_COEF]    = RST_FLOOR_UP_COEF;
                    next_setting[REG_HIGHPASS_COEF]    = RST_HIGHPASS_COEF;
                end
                SET_ZERO:
                    for (int i = 0; i < 8; i++)
                        next_setting[i] = 16'h0000;
                // top bit set on the 15-bit registers too, it must be dropped
                SET_FULL:
                    for (int i = 0; i < 8; i++)
                        next_setting[i] = 16'hFFFF;
                SET_SCRAMBLED:
                    for (int i = 0; i < 8; i++)
                        next_setting[i] = 16'($urandom);
                default: begin
                    // floor follows quickly so the noisy-room onset paths get used
                    next_setting[REG_RMS_THRESHOLD]    = 16'($urandom_range(20, 200));
                    next_setting[REG_NOISY_FLOOR]      = 16'($urandom_range(0, 300));
                    next_setting[REG_ONSET_ABS]        = 16'($urandom_range(0, 2000));
                    next_setting[REG_ONSET_REL]        = 16'($urandom_range(0, 16384));
                    next_setting[REG_SPEECH_RATIO_MIN] = 16'($urandom_range(0, 8192));
                    next_setting[REG_FLOOR_DOWN_COEF]  = 16'($urandom);
                    next_setting[REG_FLOOR_UP_COEF]    = 16'($urandom_range(0, 40000));
                    next_setting[REG_HIGHPASS_COEF]    = 16'($urandom);
                end
            endcase
            // the last stretch runs flat out on both sides
            if (setting_kind_t'(p) == SET_NOISY_FAST)
                idle_on = 1'b0;
            load_settings();
            run_hops(PHASE_WORDS);
            settle();
        end

        // drain, bounded
        begin
            int guard;
            guard = 0;
            while (results_due.size() != 0 && guard < DRAIN_GUARD) begin
                @(posedge aclk);
                guard++;
            end
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (results_due.size() != 0) begin
            $error("%0d hop results never arrived", results_due.size());
            fail_count++;
        end

        $display("run: %0d input words incl. %0d hit clears, %0d hop results checked",
                 words_sent, clears_sent, hops_checked);
        $display("run: %0d register writes over six settings plus one over-long hop",
                 cfg_writes);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #6000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
